// ===== rtl/acdp_pkg.sv =====
// Shared types, constant tables and round functions for the AES-CBC
// two-block decrypt and pad check pipeline. No dependencies.
package acdp_pkg;

    localparam int NUM_FWD_STAGES   = 13;  // key schedule walk to the last round key
    localparam int NUM_ROUND_STAGES = 13;  // middle rounds of AES-256, thirteen down to one
    localparam int ROUNDS_128       = 10;
    localparam int MAX_PAD          = 16;

    typedef logic [7:0]        byte_t;
    typedef logic [255:0][7:0] byte_tbl_t;
    typedef logic [9:0][7:0]   rcon_tbl_t;
    typedef logic [7:0][31:0]  key_win_t;   // eight-word key schedule window, [0] oldest

    typedef struct packed {
        logic [63:0] key_word_0;
        logic [63:0] key_word_1;
        logic [63:0] key_word_2;
        logic [63:0] key_word_3;
        logic [63:0] iv_high;
        logic [63:0] iv_low;
        logic [63:0] cipher_word_0;
        logic [63:0] cipher_word_1;
        logic [63:0] cipher_word_2;
        logic [63:0] cipher_word_3;
    } acdp_in_t;

    typedef struct packed {
        logic [63:0] plain_word_0;
        logic [63:0] plain_word_1;
        logic [63:0] plain_word_2;
        logic [63:0] plain_word_3;
        logic        padding_valid;
        logic [7:0]  pad_value;
    } acdp_out_t;

    typedef struct packed {
        key_win_t     key;
        logic [127:0] blk0;
        logic [127:0] blk1;
        logic [127:0] iv;
        logic [127:0] ct0;
    } acdp_pipe_t;

    typedef struct packed {
        logic [127:0] pt0;
        logic [127:0] pt1;
    } acdp_plain_t;

    function automatic byte_t xtime(input byte_t a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic byte_t gf_mul(input byte_t a, input byte_t b);
        byte_t r;
        byte_t x;
        r = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) r = r ^ x;
            x = xtime(x);
        end
        return r;
    endfunction

    // a^254, with zero mapped to zero
    function automatic byte_t gf_inv(input byte_t a);
        byte_t r;
        byte_t base;
        logic [7:0] e;
        r = 8'h01;
        base = a;
        e = 8'd254;
        for (int i = 0; i < 8; i++) begin
            if (e[i]) r = gf_mul(r, base);
            base = gf_mul(base, base);
        end
        return r;
    endfunction

    function automatic byte_t rotl8(input byte_t x, input int n);
        return byte_t'((x << n) | (x >> (8 - n)));
    endfunction

    function automatic byte_tbl_t gen_sbox();
        byte_tbl_t t;
        byte_t b;
        for (int i = 0; i < 256; i++) begin
            b = gf_inv(byte_t'(i));
            t[i] = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
        end
        return t;
    endfunction

    function automatic byte_tbl_t gen_inv_sbox();
        byte_tbl_t t;
        byte_t y;
        for (int i = 0; i < 256; i++) begin
            y = byte_t'(i);
            t[i] = gf_inv(rotl8(y, 1) ^ rotl8(y, 3) ^ rotl8(y, 6) ^ 8'h05);
        end
        return t;
    endfunction

    function automatic rcon_tbl_t gen_rcon();
        rcon_tbl_t t;
        byte_t r;
        r = 8'h01;
        for (int i = 0; i < 10; i++) begin
            t[i] = r;
            r = xtime(r);
        end
        return t;
    endfunction

    localparam byte_tbl_t SBOX     = gen_sbox();
    localparam byte_tbl_t INV_SBOX = gen_inv_sbox();
    localparam rcon_tbl_t RCON     = gen_rcon();

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // schedule core: rotate, substitute, add round constant
    function automatic logic [31:0] rot_sub(input logic [31:0] w, input byte_t rc);
        return sub_word({w[23:0], w[31:24]}) ^ {rc, 24'h000000};
    endfunction

    function automatic key_win_t key_fwd_256(input key_win_t k, input logic rs,
                                             input byte_t rc);
        key_win_t r;
        logic [31:0] t;
        t = rs ? rot_sub(k[7], rc) : sub_word(k[7]);
        r[0] = k[4];
        r[1] = k[5];
        r[2] = k[6];
        r[3] = k[7];
        r[4] = k[0] ^ t;
        r[5] = k[1] ^ r[4];
        r[6] = k[2] ^ r[5];
        r[7] = k[3] ^ r[6];
        return r;
    endfunction

    function automatic key_win_t key_fwd_128(input key_win_t k, input byte_t rc);
        key_win_t r;
        r = k;
        r[0] = k[0] ^ rot_sub(k[3], rc);
        r[1] = k[1] ^ r[0];
        r[2] = k[2] ^ r[1];
        r[3] = k[3] ^ r[2];
        return r;
    endfunction

    function automatic key_win_t key_back_256(input key_win_t k, input logic rs,
                                              input byte_t rc);
        key_win_t r;
        logic [31:0] t;
        t = rs ? rot_sub(k[3], rc) : sub_word(k[3]);
        r[0] = k[4] ^ t;
        r[1] = k[5] ^ k[4];
        r[2] = k[6] ^ k[5];
        r[3] = k[7] ^ k[6];
        r[4] = k[0];
        r[5] = k[1];
        r[6] = k[2];
        r[7] = k[3];
        return r;
    endfunction

    function automatic key_win_t key_back_128(input key_win_t k, input byte_t rc);
        key_win_t r;
        r = k;
        r[3] = k[3] ^ k[2];
        r[2] = k[2] ^ k[1];
        r[1] = k[1] ^ k[0];
        r[0] = k[0] ^ rot_sub(r[3], rc);
        return r;
    endfunction

    function automatic logic [127:0] round_key(input key_win_t k, input logic hi);
        return hi ? {k[4], k[5], k[6], k[7]} : {k[0], k[1], k[2], k[3]};
    endfunction

    // byte n of a block sits at the most significant end for n = 0
    function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (c * 4 + r) -: 8] =
                    INV_SBOX[s[127 - 8 * (((c - r) & 3) * 4 + r) -: 8]];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        logic [127:0] t;
        byte_t a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127 - 8 * (c * 4)     -: 8];
            a1 = s[127 - 8 * (c * 4 + 1) -: 8];
            a2 = s[127 - 8 * (c * 4 + 2) -: 8];
            a3 = s[127 - 8 * (c * 4 + 3) -: 8];
            t[127 - 8 * (c * 4) -: 8] = gf_mul(a0, 8'd14) ^ gf_mul(a1, 8'd11) ^
                                        gf_mul(a2, 8'd13) ^ gf_mul(a3, 8'd9);
            t[127 - 8 * (c * 4 + 1) -: 8] = gf_mul(a0, 8'd9) ^ gf_mul(a1, 8'd14) ^
                                            gf_mul(a2, 8'd11) ^ gf_mul(a3, 8'd13);
            t[127 - 8 * (c * 4 + 2) -: 8] = gf_mul(a0, 8'd13) ^ gf_mul(a1, 8'd9) ^
                                            gf_mul(a2, 8'd14) ^ gf_mul(a3, 8'd11);
            t[127 - 8 * (c * 4 + 3) -: 8] = gf_mul(a0, 8'd11) ^ gf_mul(a1, 8'd13) ^
                                            gf_mul(a2, 8'd9) ^ gf_mul(a3, 8'd14);
        end
        return t;
    endfunction

endpackage

// ===== rtl/acdp_key_fwd_stage.sv =====
// One pipeline stage of the forward key schedule walk (four words a stage).
// Depends on acdp_pkg.
module acdp_key_fwd_stage #(
    parameter int STAGE = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               key_is_256,
    input  logic               in_valid,
    output logic               in_ready,
    input  acdp_pkg::acdp_pipe_t in_pipe,
    output logic               out_valid,
    input  logic               out_ready,
    output acdp_pkg::acdp_pipe_t out_pipe
);
    import acdp_pkg::*;

    localparam byte_t RC_256 = RCON[STAGE / 2];
    localparam byte_t RC_128 = RCON[STAGE % ROUNDS_128];
    localparam logic  RS_256 = ((STAGE % 2) == 0);
    localparam logic  ACT_128 = (STAGE < ROUNDS_128);

    logic       valid_reg;
    acdp_pipe_t pipe_reg;
    acdp_pipe_t pipe_next;

    // step the schedule window forward by four words
    always_comb begin
        pipe_next = in_pipe;
        if (key_is_256) begin
            pipe_next.key = key_fwd_256(in_pipe.key, RS_256, RC_256);
        end else if (ACT_128) begin
            pipe_next.key = key_fwd_128(in_pipe.key, RC_128);
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            pipe_reg <= pipe_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pipe  = pipe_reg;
endmodule

// ===== rtl/acdp_round_stage.sv =====
// One inverse AES round on both blocks, with the key schedule stepped back
// one round key in parallel; the upper rounds pass through in AES-128 mode. Depends on acdp_pkg.
module acdp_round_stage #(
    parameter int ROUND = 13
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               key_is_256,
    input  logic               in_valid,
    output logic               in_ready,
    input  acdp_pkg::acdp_pipe_t in_pipe,
    output logic               out_valid,
    input  logic               out_ready,
    output acdp_pkg::acdp_pipe_t out_pipe
);
    import acdp_pkg::*;

    localparam byte_t RC_256  = RCON[(ROUND + 1) / 2 - 1];
    localparam byte_t RC_128  = RCON[(ROUND - 1) % ROUNDS_128];
    localparam logic  RS_256  = ((ROUND % 2) == 1);
    localparam logic  ACT_128 = (ROUND < ROUNDS_128);

    logic         valid_reg;
    acdp_pipe_t   pipe_reg;
    acdp_pipe_t   pipe_next;
    logic [127:0] rk;

    assign rk = round_key(in_pipe.key, 1'b0);

    // run the round; in AES-128 mode the upper rounds pass the word through
    always_comb begin
        pipe_next = in_pipe;
        if (key_is_256 || ACT_128) begin
            pipe_next.blk0 = inv_mix(inv_shift_sub(in_pipe.blk0) ^ rk);
            pipe_next.blk1 = inv_mix(inv_shift_sub(in_pipe.blk1) ^ rk);
            pipe_next.key  = key_is_256 ? key_back_256(in_pipe.key, RS_256, RC_256)
                                        : key_back_128(in_pipe.key, RC_128);
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            pipe_reg <= pipe_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pipe  = pipe_reg;
endmodule

// ===== rtl/acdp_edge_stage.sv =====
// Initial and final AES round stages: first round key add, or last inverse
// round plus CBC chaining. Depends on acdp_pkg.
module acdp_edge_stage #(
    parameter bit IS_FINAL = 1'b0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               key_is_256,
    input  logic               in_valid,
    output logic               in_ready,
    input  acdp_pkg::acdp_pipe_t in_pipe,
    output logic               out_valid,
    input  logic               out_ready,
    output acdp_pkg::acdp_pipe_t out_pipe
);
    import acdp_pkg::*;

    logic         valid_reg;
    acdp_pipe_t   pipe_reg;
    acdp_pipe_t   pipe_next;
    logic [127:0] rk;
    logic [127:0] b0;
    logic [127:0] b1;

    // initial add uses the last round key; AES-256 keeps it in the upper half
    assign rk = round_key(in_pipe.key, !IS_FINAL && key_is_256);

    always_comb begin
        pipe_next = in_pipe;
        if (IS_FINAL) begin
            b0 = inv_shift_sub(in_pipe.blk0) ^ rk;
            b1 = inv_shift_sub(in_pipe.blk1) ^ rk;
            pipe_next.blk0 = b0 ^ in_pipe.iv;
            pipe_next.blk1 = b1 ^ in_pipe.ct0;
        end else begin
            b0 = in_pipe.blk0 ^ rk;
            b1 = in_pipe.blk1 ^ rk;
            pipe_next.blk0 = b0;
            pipe_next.blk1 = b1;
            if (!key_is_256) begin
                pipe_next.key = key_back_128(in_pipe.key, RCON[ROUNDS_128 - 1]);
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            pipe_reg <= pipe_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pipe  = pipe_reg;
endmodule

// ===== rtl/acdp_pad_stage.sv =====
// Output register stage: PKCS7 pad check on the second plaintext block.
// Depends on acdp_pkg.
module acdp_pad_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  acdp_pkg::acdp_plain_t in_plain,
    output logic                out_valid,
    input  logic                out_ready,
    output acdp_pkg::acdp_out_t   out_data
);
    import acdp_pkg::*;

    logic      valid_reg;
    acdp_out_t data_reg;
    acdp_out_t data_next;
    byte_t     pad;
    logic      ok;

    assign pad = in_plain.pt1[7:0];

    // check the last pad bytes against the pad value
    always_comb begin
        ok = (pad >= 8'd1) && (pad <= 8'(MAX_PAD));
        for (int i = 0; i < MAX_PAD; i++) begin
            if ((8'(i) < pad) && (in_plain.pt1[8 * i +: 8] != pad)) ok = 1'b0;
        end
        data_next.plain_word_0  = in_plain.pt0[127:64];
        data_next.plain_word_1  = in_plain.pt0[63:0];
        data_next.plain_word_2  = in_plain.pt1[127:64];
        data_next.plain_word_3  = in_plain.pt1[63:0];
        data_next.padding_valid = ok;
        data_next.pad_value     = pad;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

// ===== rtl/aes_cbc_decrypt_pad_check_core.sv =====
// Top level of the AES-CBC two-block decrypt and PKCS7 pad check pipeline.
// Depends on acdp_pkg and the acdp stage modules.
//
// Usage:
//   s_valid/s_ready/s_data carry one word: candidate key, IV and two
//   ciphertext blocks. m_valid/m_ready/m_data return both plaintext blocks,
//   the last plaintext byte and the pad-valid flag, one result per word.
//   cfg_valid/cfg_ready/cfg_data write key_is_256 (1 = AES-256, 0 = AES-128
//   with key words 0-1); cfg_ready is always high. Write it only while idle.
// Path from input accept to m_valid: 13 key schedule stages, the initial key
//   add, 13 inverse rounds (the upper four pass through in AES-128 mode), the
//   final round with CBC xor, and the pad check register.
// Throughput: one word per cycle while the output is not stalled; every stage
//   is a register with its own valid bit, so a new word enters each cycle.
// Reset: aresetn (synchronous, active low) empties the pipeline and sets
//   key_is_256 to 1.
// Stall: when m_ready is low, words pile up in empty stages first; s_ready
//   drops only once every stage is full. Nothing is dropped or repeated.
module aes_cbc_decrypt_pad_check_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  acdp_pkg::acdp_in_t    s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output acdp_pkg::acdp_out_t   m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data
);
    import acdp_pkg::*;

    localparam int NUM_MID = NUM_FWD_STAGES + 1 + NUM_ROUND_STAGES + 1;

    logic        key_is_256_reg;
    acdp_pipe_t  in_pipe;
    acdp_pipe_t  pipe   [NUM_MID + 1];
    logic        pvalid [NUM_MID + 1];
    logic        pready [NUM_MID + 1];
    acdp_plain_t plain;

    // hold the key size register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_is_256_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            key_is_256_reg <= cfg_data;
        end
    end

    // unpack the input word into schedule words and blocks
    always_comb begin
        in_pipe.key[0] = s_data.key_word_0[63:32];
        in_pipe.key[1] = s_data.key_word_0[31:0];
        in_pipe.key[2] = s_data.key_word_1[63:32];
        in_pipe.key[3] = s_data.key_word_1[31:0];
        in_pipe.key[4] = s_data.key_word_2[63:32];
        in_pipe.key[5] = s_data.key_word_2[31:0];
        in_pipe.key[6] = s_data.key_word_3[63:32];
        in_pipe.key[7] = s_data.key_word_3[31:0];
        in_pipe.blk0   = {s_data.cipher_word_0, s_data.cipher_word_1};
        in_pipe.blk1   = {s_data.cipher_word_2, s_data.cipher_word_3};
        in_pipe.iv     = {s_data.iv_high, s_data.iv_low};
        in_pipe.ct0    = {s_data.cipher_word_0, s_data.cipher_word_1};
    end

    assign pipe[0]   = in_pipe;
    assign pvalid[0] = s_valid;
    assign s_ready   = pready[0];

    // forward key schedule walk
    for (genvar g = 0; g < NUM_FWD_STAGES; g++) begin : g_fwd
        acdp_key_fwd_stage #(.STAGE(g)) u_fwd (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .key_is_256 (key_is_256_reg),
            .in_valid   (pvalid[g]),
            .in_ready   (pready[g]),
            .in_pipe    (pipe[g]),
            .out_valid  (pvalid[g + 1]),
            .out_ready  (pready[g + 1]),
            .out_pipe   (pipe[g + 1])
        );
    end

    // initial round key add
    acdp_edge_stage #(.IS_FINAL(1'b0)) u_init (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .key_is_256 (key_is_256_reg),
        .in_valid   (pvalid[NUM_FWD_STAGES]),
        .in_ready   (pready[NUM_FWD_STAGES]),
        .in_pipe    (pipe[NUM_FWD_STAGES]),
        .out_valid  (pvalid[NUM_FWD_STAGES + 1]),
        .out_ready  (pready[NUM_FWD_STAGES + 1]),
        .out_pipe   (pipe[NUM_FWD_STAGES + 1])
    );

    // middle inverse rounds, highest round first
    for (genvar g = 0; g < NUM_ROUND_STAGES; g++) begin : g_round
        localparam int IDX = NUM_FWD_STAGES + 1 + g;
        acdp_round_stage #(.ROUND(NUM_ROUND_STAGES - g)) u_round (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .key_is_256 (key_is_256_reg),
            .in_valid   (pvalid[IDX]),
            .in_ready   (pready[IDX]),
            .in_pipe    (pipe[IDX]),
            .out_valid  (pvalid[IDX + 1]),
            .out_ready  (pready[IDX + 1]),
            .out_pipe   (pipe[IDX + 1])
        );
    end

    // last round and CBC chaining
    acdp_edge_stage #(.IS_FINAL(1'b1)) u_final (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .key_is_256 (key_is_256_reg),
        .in_valid   (pvalid[NUM_MID - 1]),
        .in_ready   (pready[NUM_MID - 1]),
        .in_pipe    (pipe[NUM_MID - 1]),
        .out_valid  (pvalid[NUM_MID]),
        .out_ready  (pready[NUM_MID]),
        .out_pipe   (pipe[NUM_MID])
    );

    assign plain.pt0 = pipe[NUM_MID].blk0;
    assign plain.pt1 = pipe[NUM_MID].blk1;

    // pad check and output register
    acdp_pad_stage u_pad (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (pvalid[NUM_MID]),
        .in_ready  (pready[NUM_MID]),
        .in_plain  (plain),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );
endmodule

// ===== rtl/acdp_checker.sv =====
// Port-level checks for the decrypt and pad check core, bound to the top.
// Depends on acdp_pkg and aes_cbc_decrypt_pad_check_core.
module acdp_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input acdp_pkg::acdp_out_t   m_data
);
    import acdp_pkg::*;

    // a waiting input word stays offered until accepted
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid)
        else $error("input word withdrawn before accept");

    // a stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // reset empties the pipeline
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // pad value is the last plaintext byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.pad_value == m_data.plain_word_3[7:0])
        else $error("pad value does not match last byte");

    // a valid pad lies in range and, for a pad above one, its neighbor byte agrees
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.padding_valid |->
            m_data.pad_value >= 8'd1 && m_data.pad_value <= 8'(MAX_PAD) &&
            (m_data.pad_value == 8'd1 ||
             m_data.plain_word_3[15:8] == m_data.pad_value))
        else $error("padding flagged valid on bad pad bytes");
endmodule

bind aes_cbc_decrypt_pad_check_core acdp_checker u_acdp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
